[src/assert_macros.svh]
// Assertion macros shared by the RTL of the hourly schedule dimmer.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication failed");

`endif

[src/hsd_pkg.sv]
// Shared types and constants for the hourly schedule dimmer.
// No dependencies; imported by the multiplier, the top level and the testbench.
package hsd_pkg;

    // Field widths of the input and result beats.
    localparam int OPCODE_W = 2;
    localparam int CHAN_W   = 3;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int LEVEL_W  = 16;

    // Interpolation runs over one hour of minutes.
    localparam int MINUTES_PER_HOUR = 60;
    localparam logic [MINUTE_W-1:0] MINUTE_MAX = MINUTE_W'(MINUTES_PER_HOUR - 1);

    // Division by 60 is a shift by two followed by a multiply with the
    // rounded-up reciprocal of 15. The error term stays below one part in
    // fifteen for every dividend this block can produce, so the floor is exact.
    localparam int DIV_PRE_SHIFT = 2;
    localparam int DIV_ODD       = MINUTES_PER_HOUR >> DIV_PRE_SHIFT;
    localparam int RECIP_SHIFT   = 24;
    localparam int RECIP_VAL     = ((1 << RECIP_SHIFT) + DIV_ODD - 1) / DIV_ODD;

    // Shared multiplier operand and product widths.
    localparam int MUL_A_W = 20;
    localparam int MUL_B_W = 21;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic [MUL_B_W-1:0] RECIP = MUL_B_W'(RECIP_VAL);

    // Input operation codes.
    typedef enum logic [OPCODE_W-1:0] {
        OP_WRITE   = 2'd0,
        OP_TIME    = 2'd1,
        OP_TURN_ON = 2'd2
    } op_t;

endpackage

[src/hsd_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the per-channel schedule table.
module hsd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 144
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/hsd_mul.sv]
// Shared multiplier with a registered product, reused for every step.
// Depends on hsd_pkg for operand widths.
module hsd_mul
    import hsd_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [MUL_A_W-1:0] a,
    input  logic [MUL_B_W-1:0] b,
    output logic [MUL_P_W-1:0] p
);

    logic [MUL_P_W-1:0] p_reg;

    // The product holds until the next enabled cycle.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= MUL_P_W'(a) * MUL_P_W'(b);
        end
    end

    assign p = p_reg;

endmodule

[src/hourly_schedule_dimmer.sv]
// Top level of the hourly schedule dimmer: sequencer, schedule RAM, multiplier.
// Depends on hsd_pkg, hsd_ram, hsd_mul and assert_macros.svh.
//
//   Channel   Handshake             Payload
//   input     in_valid / in_stall   opcode, channel, hour, minute, level
//   output    out_valid / out_stall out_channel, duty, last
//
// After reset a clearing pass zeroes all CHANNELS * SLOTS_PER_DAY entries (144 by
// default) with in_stall high. A write is done in the idle state; a turn-on or a time beat
// scans the channels to serve, and for each one reads the current and next slot, forms the
// difference, multiplies by the minute and divides by 60, then emits the duty.
// Each duty costs two table reads and two multiplier passes. While a result is held
// by out_stall the sequencer waits in its emit step; the input stalls until idle.
`include "assert_macros.svh"

module hourly_schedule_dimmer
    import hsd_pkg::*;
#(
    parameter int CHANNELS      = 6,
    parameter int SLOTS_PER_DAY = 24,
    parameter int DUTY_BITS     = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [OPCODE_W-1:0] opcode,
    input  logic [CHAN_W-1:0]   channel,
    input  logic [HOUR_W-1:0]   hour,
    input  logic [MINUTE_W-1:0] minute,
    input  logic [LEVEL_W-1:0]  level,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [CHAN_W-1:0]   out_channel,
    output logic [LEVEL_W-1:0]  duty,
    output logic                last
);

    localparam int DEPTH  = CHANNELS * SLOTS_PER_DAY;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SLOT_W = $clog2(SLOTS_PER_DAY);
    localparam int HOURS  = 2 ** HOUR_W;

    // Saturation limit of the duty, held to the width of the sum.
    localparam longint unsigned DUTY_MAX_L = (64'd1 << DUTY_BITS) - 64'd1;
    localparam logic [LEVEL_W:0] DUTY_CAP =
        (DUTY_MAX_L > 64'h1FFFF) ? {(LEVEL_W+1){1'b1}} : (LEVEL_W+1)'(DUTY_MAX_L);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_RD_CUR,
        S_RD_NXT,
        S_DIFF,
        S_MUL1,
        S_MUL2,
        S_EMIT
    } state_t;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [CHANNELS-1:0] enabled_reg, enabled_next;
    logic [CHANNELS-1:0] pending_reg, pending_next;
    logic [CH_W-1:0]     ch_reg, ch_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [SLOT_W-1:0]   nslot_reg, nslot_next;
    logic [MINUTE_W-1:0] min_reg, min_next;
    logic [LEVEL_W-1:0]  cur_reg, cur_next;
    logic                neg_reg, neg_next;
    logic [LEVEL_W-1:0]  mag_reg, mag_next;
    logic                out_valid_reg, out_valid_next;
    logic [CHAN_W-1:0]   out_channel_reg, out_channel_next;
    logic [LEVEL_W-1:0]  duty_reg, duty_next;
    logic                last_reg, last_next;

    logic [SLOT_W-1:0]   slot_lut [HOURS];
    logic [SLOT_W-1:0]   in_slot;
    logic [CH_W-1:0]     ch_in;
    logic                in_accept;
    logic                out_free;
    logic                out_load;
    logic                emit_last;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [LEVEL_W-1:0]  ram_wdata;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [LEVEL_W-1:0]  ram_rdata;
    logic [SLOT_W-1:0]   rd_slot;

    logic                mul_en;
    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [MUL_P_W-1:0]  mul_p;

    logic [LEVEL_W:0]    diff;
    logic [LEVEL_W-1:0]  quot;
    logic [LEVEL_W:0]    sum_val;
    logic [LEVEL_W:0]    sat_val;

    // Hour to slot table, hour taken modulo the number of slots.
    for (genvar g = 0; g < HOURS; g++)
    begin : g_slot
        localparam int SLOT_OF = g % SLOTS_PER_DAY;
        assign slot_lut[g] = SLOT_W'(SLOT_OF);
    end

    assign in_slot   = slot_lut[hour];
    assign ch_in     = CH_W'(channel);
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_load  = (state_reg == S_EMIT) && out_free;
    assign emit_last = (pending_reg == '0);

    // Table port control: the clearing pass and writes share the write port.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = clr_cnt_reg;
        ram_wdata = '0;
        if (state_reg == S_CLEAR)
        begin
            ram_we = 1'b1;
        end
        else if (in_accept && (opcode == OP_WRITE) && (int'(channel) < CHANNELS)
                 && (int'(hour) < SLOTS_PER_DAY))
        begin
            ram_we    = 1'b1;
            ram_waddr = ADDR_W'(int'(channel) * SLOTS_PER_DAY + int'(hour));
            ram_wdata = level;
        end
    end

    // Reads fetch the current slot first, then the next slot.
    assign rd_slot   = (state_reg == S_RD_NXT) ? nslot_reg : slot_reg;
    assign ram_re    = (state_reg == S_RD_CUR) || (state_reg == S_RD_NXT);
    assign ram_raddr = ADDR_W'(int'(ch_reg) * SLOTS_PER_DAY + int'(rd_slot));

    // Multiplier operands: level difference times minute, then divide by 60.
    always_comb
    begin
        mul_en = 1'b0;
        mul_a  = MUL_A_W'(mag_reg);
        mul_b  = MUL_B_W'(min_reg);
        if (state_reg == S_MUL1)
        begin
            mul_en = 1'b1;
        end
        else if (state_reg == S_MUL2)
        begin
            mul_en = 1'b1;
            mul_a  = mul_p[MUL_A_W+DIV_PRE_SHIFT-1:DIV_PRE_SHIFT];
            mul_b  = RECIP;
        end
    end

    // Signed difference and the final sum with saturation.
    assign diff    = {1'b0, ram_rdata} - {1'b0, cur_reg};
    assign quot    = mul_p[RECIP_SHIFT +: LEVEL_W];
    assign sum_val = neg_reg ? ({1'b0, cur_reg} - {1'b0, quot})
                             : ({1'b0, cur_reg} + {1'b0, quot});
    assign sat_val = (sum_val > DUTY_CAP) ? DUTY_CAP : sum_val;

    // Sequencer next-state logic.
    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        enabled_next     = enabled_reg;
        pending_next     = pending_reg;
        ch_next          = ch_reg;
        slot_next        = slot_reg;
        nslot_next       = nslot_reg;
        min_next         = min_reg;
        cur_next         = cur_reg;
        neg_next         = neg_reg;
        mag_next         = mag_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_channel_next = out_channel_reg;
        duty_next        = duty_reg;
        last_next        = last_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    slot_next  = in_slot;
                    nslot_next = (in_slot == SLOT_W'(SLOTS_PER_DAY - 1)) ? '0
                                                                         : in_slot + 1'b1;
                    min_next   = (minute > MINUTE_MAX) ? MINUTE_MAX : minute;
                    case (opcode)
                        OP_TIME:
                        begin
                            pending_next = enabled_reg;
                            ch_next      = '0;
                            state_next   = S_SCAN;
                        end
                        OP_TURN_ON:
                        begin
                            if (int'(channel) < CHANNELS)
                            begin
                                enabled_next = enabled_reg | (CHANNELS'(1) << ch_in);
                                pending_next = CHANNELS'(1) << ch_in;
                                ch_next      = ch_in;
                                state_next   = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (pending_reg == '0)
                begin
                    state_next = S_IDLE;
                end
                else if (pending_reg[ch_reg])
                begin
                    state_next = S_RD_CUR;
                end
                else
                begin
                    ch_next = ch_reg + 1'b1;
                end
            end
            S_RD_CUR:
            begin
                pending_next         = pending_reg;
                pending_next[ch_reg] = 1'b0;
                state_next           = S_RD_NXT;
            end
            S_RD_NXT:
            begin
                cur_next   = ram_rdata;
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                neg_next   = diff[LEVEL_W];
                mag_next   = diff[LEVEL_W] ? LEVEL_W'(-diff) : diff[LEVEL_W-1:0];
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_channel_next = CHAN_W'(ch_reg);
                    duty_next        = sat_val[LEVEL_W-1:0];
                    last_next        = emit_last;
                    if (emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ch_next    = ch_reg + 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_cnt_reg     <= '0;
            enabled_reg     <= '0;
            pending_reg     <= '0;
            ch_reg          <= '0;
            slot_reg        <= '0;
            nslot_reg       <= '0;
            min_reg         <= '0;
            cur_reg         <= '0;
            neg_reg         <= 1'b0;
            mag_reg         <= '0;
            out_valid_reg   <= 1'b0;
            out_channel_reg <= '0;
            duty_reg        <= '0;
            last_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_cnt_reg     <= clr_cnt_next;
            enabled_reg     <= enabled_next;
            pending_reg     <= pending_next;
            ch_reg          <= ch_next;
            slot_reg        <= slot_next;
            nslot_reg       <= nslot_next;
            min_reg         <= min_next;
            cur_reg         <= cur_next;
            neg_reg         <= neg_next;
            mag_reg         <= mag_next;
            out_valid_reg   <= out_valid_next;
            out_channel_reg <= out_channel_next;
            duty_reg        <= duty_next;
            last_reg        <= last_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_channel = out_channel_reg;
    assign duty        = duty_reg;
    assign last        = last_reg;

    // Schedule table.
    hsd_ram #(
        .WIDTH (LEVEL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared multiplier.
    hsd_mul u_mul (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    // Channels still to be served are always enabled channels.
    `ASSERT_IMPLY(a_pending_enabled, clk, rst_n, 1'b1, (pending_reg & ~enabled_reg) == '0)
    // The table is written only by the clearing pass or by an idle write beat.
    `ASSERT_IMPLY(a_ram_we_state, clk, rst_n, ram_we, (state_reg == S_CLEAR) || (state_reg == S_IDLE))
    // Loading the final beat of an item returns the sequencer to idle.
    `ASSERT_NEXT(a_last_idle, clk, rst_n, out_load && emit_last, state_reg == S_IDLE)

endmodule

[dv/hourly_schedule_dimmer_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the hourly schedule dimmer top level.
// Depends on hsd_pkg and hourly_schedule_dimmer; predicts every duty beat and checks it.
module hourly_schedule_dimmer_tb
    import hsd_pkg::*;
();

    localparam int NUM_CH       = 6;
    localparam int NUM_SLOTS    = 24;
    localparam int DUTY_MAX     = (1 << 16) - 1;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 50;
    localparam int HOLD_CYCLES  = 200;

    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [CHAN_W-1:0]  chan;
        logic [LEVEL_W-1:0] duty;
        logic               last;
    } duty_beat_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [OPCODE_W-1:0] opcode = '0;
    logic [CHAN_W-1:0]   channel = '0;
    logic [HOUR_W-1:0]   hour = '0;
    logic [MINUTE_W-1:0] minute = '0;
    logic [LEVEL_W-1:0]  level = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [CHAN_W-1:0]   out_channel;
    logic [LEVEL_W-1:0]  duty;
    logic                last;

    // Shadow copy of the schedule table and the enable mask.
    logic [LEVEL_W-1:0] sched_level [NUM_CH][NUM_SLOTS];
    logic [NUM_CH-1:0]  chan_on;
    duty_beat_t         expected_duties [$];

    int send_idle_pct = 0;
    int out_stall_pct = 0;
    int hold_request  = 0;
    int hold_left     = 0;
    int fail_count    = 0;
    int cycle_count   = 0;

    hourly_schedule_dimmer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .channel     (channel),
        .hour        (hour),
        .minute      (minute),
        .level       (level),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_channel (out_channel),
        .duty        (duty),
        .last        (last)
    );

    // 4 ns clock.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Run watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Output back-pressure: a requested hold-off first, random stalls otherwise.
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    // Compare every accepted result beat with the oldest expected one.
    always @(posedge clk)
    begin
        duty_beat_t exp_beat;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_duties.size() == 0)
            begin
                $error("unexpected result beat: out_channel %0d duty %0d last %0d",
                       out_channel, duty, last);
                fail_count++;
            end
            else
            begin
                exp_beat = expected_duties.pop_front();
                if (out_channel !== exp_beat.chan)
                begin
                    $error("out_channel: expected %0d, actual %0d", exp_beat.chan, out_channel);
                    fail_count++;
                end
                if (duty !== exp_beat.duty)
                begin
                    $error("duty: expected %0d, actual %0d", exp_beat.duty, duty);
                    fail_count++;
                end
                if (last !== exp_beat.last)
                begin
                    $error("last: expected %0d, actual %0d", exp_beat.last, last);
                    fail_count++;
                end
            end
        end
    end

    // Level at the current slot plus the signed share of the step to the next slot.
    function automatic logic [LEVEL_W-1:0] interpolated_duty(int ch, logic [HOUR_W-1:0] hr,
                                                             logic [MINUTE_W-1:0] mn);
        int     slot;
        int     next_slot;
        int     mins;
        longint cur;
        longint nxt;
        longint val;
        slot      = int'(hr) % NUM_SLOTS;
        next_slot = (slot + 1) % NUM_SLOTS;
        mins      = (mn > MINUTE_MAX) ? int'(MINUTE_MAX) : int'(mn);
        cur       = longint'(sched_level[ch][slot]);
        nxt       = longint'(sched_level[ch][next_slot]);
        // Signed division truncates toward zero.
        val = cur + ((nxt - cur) * mins) / MINUTES_PER_HOUR;
        if (val < 0)
            val = 0;
        if (val > DUTY_MAX)
            val = DUTY_MAX;
        return val[LEVEL_W-1:0];
    endfunction

    // Update the shadow state for one accepted beat and queue the duties it causes.
    task automatic predict_duties(logic [OPCODE_W-1:0] op, logic [CHAN_W-1:0] ch,
                                  logic [HOUR_W-1:0] hr, logic [MINUTE_W-1:0] mn,
                                  logic [LEVEL_W-1:0] lv);
        int last_on;
        last_on = -1;
        case (op)
            OP_WRITE:
            begin
                if (ch < NUM_CH && hr < NUM_SLOTS)
                    sched_level[ch][hr] = lv;
            end
            OP_TIME:
            begin
                for (int i = 0; i < NUM_CH; i++)
                    if (chan_on[i])
                        last_on = i;
                for (int i = 0; i < NUM_CH; i++)
                    if (chan_on[i])
                        expected_duties.push_back('{CHAN_W'(i), interpolated_duty(i, hr, mn),
                                                   (i == last_on)});
            end
            OP_TURN_ON:
            begin
                if (ch < NUM_CH)
                begin
                    chan_on[ch] = 1'b1;
                    expected_duties.push_back('{ch, interpolated_duty(int'(ch), hr, mn), 1'b1});
                end
            end
            default:
            begin
                // The unused opcode leaves everything as it is.
            end
        endcase
    endtask

    // Offer one beat after a random gap and wait until the block takes it.
    task automatic send_beat(logic [OPCODE_W-1:0] op, logic [CHAN_W-1:0] ch,
                             logic [HOUR_W-1:0] hr, logic [MINUTE_W-1:0] mn,
                             logic [LEVEL_W-1:0] lv);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        channel  <= ch;
        hour     <= hr;
        minute   <= mn;
        level    <= lv;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_duties(op, ch, hr, mn, lv);
    endtask

    // Levels lean toward the extremes so that large steps show up often.
    function automatic logic [LEVEL_W-1:0] random_level();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            default: return LEVEL_W'($urandom_range(DUTY_MAX));
        endcase
    endfunction

    task automatic send_random_beat();
        int                  pick;
        logic [OPCODE_W-1:0] op;
        logic [CHAN_W-1:0]   ch;
        logic [HOUR_W-1:0]   hr;
        logic [MINUTE_W-1:0] mn;
        logic [LEVEL_W-1:0]  lv;
        pick = int'($urandom_range(99));
        ch   = CHAN_W'($urandom_range(NUM_CH - 1));
        hr   = HOUR_W'($urandom_range(NUM_SLOTS - 1));
        mn   = MINUTE_W'($urandom_range(MINUTE_MAX));
        lv   = random_level();
        if (pick < 40)
            op = OP_WRITE;
        else if (pick < 75)
            op = OP_TIME;
        else if (pick < 88)
            op = OP_TURN_ON;
        else
        begin
            // Noise: any bit pattern in every field.
            op = OPCODE_W'($urandom_range(3));
            ch = CHAN_W'($urandom_range(7));
            hr = HOUR_W'($urandom_range(31));
            mn = MINUTE_W'($urandom_range(63));
            lv = LEVEL_W'($urandom);
        end
        send_beat(op, ch, hr, mn, lv);
    endtask

    // Drop valid, wait until every expected duty has come, then let the block settle.
    task automatic wait_for_duties();
        in_valid <= 1'b0;
        while (expected_duties.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Extremes and the corner cases of the table and the mask.
    task automatic test_directed();
        send_idle_pct = 0;
        out_stall_pct = 0;
        // Nothing enabled yet: a time beat gives no duty.
        send_beat(OP_TIME, 3'd0, 5'd0, 6'd0, 16'h0000);
        send_beat(OP_UNUSED, 3'd7, 5'd31, 6'd63, 16'hFFFF);
        // Channel out of range on turn-on and write.
        send_beat(OP_TURN_ON, 3'd6, 5'd0, 6'd0, 16'h0000);
        send_beat(OP_TURN_ON, 3'd7, 5'd31, 6'd63, 16'hFFFF);
        send_beat(OP_WRITE, 3'd7, 5'd0, 6'd0, 16'hFFFF);
        // Slot out of range on write.
        send_beat(OP_WRITE, 3'd0, 5'd31, 6'd0, 16'hFFFF);
        // Wrap from the last slot to slot zero with a falling level.
        send_beat(OP_WRITE, 3'd0, 5'd23, 6'd0, 16'hFFFF);
        send_beat(OP_WRITE, 3'd0, 5'd0, 6'd0, 16'h0000);
        send_beat(OP_TURN_ON, 3'd0, 5'd23, 6'd30, 16'h0000);
        // Already on, minute above 59.
        send_beat(OP_TURN_ON, 3'd0, 5'd23, 6'd63, 16'h0000);
        // Rising step on the top channel, hour taken modulo the day.
        send_beat(OP_WRITE, 3'd5, 5'd5, 6'd0, 16'h0001);
        send_beat(OP_WRITE, 3'd5, 5'd6, 6'd0, 16'hFFFE);
        send_beat(OP_TURN_ON, 3'd5, 5'd29, 6'd45, 16'h0000);
        send_beat(OP_TIME, 3'd0, 5'd31, 6'd59, 16'h0000);
        send_beat(OP_TIME, 3'd0, 5'd22, 6'd1, 16'h0000);
        send_beat(OP_WRITE, 3'd2, 5'd0, 6'd0, 16'h5555);
        send_beat(OP_WRITE, 3'd2, 5'd1, 6'd0, 16'hAAAA);
        send_beat(OP_TURN_ON, 3'd2, 5'd0, 6'd0, 16'h0000);
        send_beat(OP_TIME, 3'd0, 5'd0, 6'd63, 16'h0000);
        send_beat(OP_TIME, 3'd0, 5'd23, 6'd59, 16'h0000);
        wait_for_duties();
    endtask

    task automatic test_random(int idle_pct, int stall_pct);
        send_idle_pct = idle_pct;
        out_stall_pct = stall_pct;
        repeat (PHASE_ITEMS) send_random_beat();
    endtask

    // Hold the output off while time beats keep coming, so the block backs up.
    task automatic test_backpressure();
        send_idle_pct = 0;
        out_stall_pct = 0;
        hold_request  = HOLD_CYCLES;
        for (int i = 0; i < NUM_CH; i++)
            send_beat(OP_TURN_ON, CHAN_W'(i), HOUR_W'($urandom_range(31)),
                      MINUTE_W'($urandom_range(63)), 16'h0000);
        repeat (20)
            send_beat(OP_TIME, 3'd0, HOUR_W'($urandom_range(NUM_SLOTS - 1)),
                      MINUTE_W'($urandom_range(MINUTE_MAX)), 16'h0000);
        wait_for_duties();
    endtask

    initial
    begin
        for (int c = 0; c < NUM_CH; c++)
            for (int s = 0; s < NUM_SLOTS; s++)
                sched_level[c][s] = '0;
        chan_on = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random(0, 0);
        test_random(55, 0);
        test_random(0, 55);
        test_random(8, 8);
        test_backpressure();
        test_random(0, 0);

        send_idle_pct = 0;
        out_stall_pct = 0;
        wait_for_duties();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
